### rtl/rcpwc_pkg.sv
// Package for the RC pulse width capture block: state, command and status
// types, result codes and register constants shared by every module.
// No dependencies.
`default_nettype none

package rcpwc_pkg;

    // Scale factor from timer ticks to microseconds
    localparam int unsigned US_BITS = 20;
    localparam logic [US_BITS-1:0] US_PER_SECOND = 20'd1000000;

    localparam int unsigned CLK_BITS   = 28;
    localparam int unsigned WIDTH_BITS = 16;
    localparam int unsigned TICK_BITS  = 32;

    localparam logic [CLK_BITS-1:0]   RESET_CLOCK_HZ = 28'd1000000;
    localparam logic [WIDTH_BITS-1:0] RESET_MIN_US   = 16'd800;
    localparam logic [WIDTH_BITS-1:0] RESET_MAX_US   = 16'd2200;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [1:0] REG_CLOCK_HZ = 2'd0;
    localparam logic [1:0] REG_MIN_US   = 2'd1;
    localparam logic [1:0] REG_MAX_US   = 2'd2;

    typedef enum logic [1:0] {
        STATUS_RISE    = 2'd0,
        STATUS_ACCEPT  = 2'd1,
        STATUS_REJECT  = 2'd2,
        STATUS_NO_RISE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_COMMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming event
        logic mul;       // load tick difference times one million into the divider
        logic div_step;  // one restoring division step
        logic commit;    // update state and load the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fall_armed;  // latched event is a falling edge while armed
        logic out_free;    // output register can take a result this cycle
    } sts_t;

endpackage

`default_nettype wire

### rtl/rcpwc_ctrl.sv
// Controller for the RC pulse width capture block: sequences capture,
// multiply, bit-serial division and commit. Depends on rcpwc_pkg.
`default_nettype none

module rcpwc_ctrl #(
    parameter int unsigned COUNTER_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  rcpwc_pkg::sts_t    sts,
    output rcpwc_pkg::cmd_t    cmd
);
    import rcpwc_pkg::*;

    localparam int unsigned PROD_W = COUNTER_BITS + US_BITS;
    localparam int unsigned CNT_W  = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.fall_armed)
                begin
                    cmd.mul    = 1'b1;
                    count_next = '0;
                    state_next = ST_DIV;
                end
                else if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/rcpwc_dp.sv
// Datapath for the RC pulse width capture block: event latch, armed state,
// multiplier, restoring divider, limit check and output register.
// Depends on rcpwc_pkg.
`default_nettype none

module rcpwc_dp #(
    parameter int unsigned COUNTER_BITS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  rcpwc_pkg::cmd_t                            cmd,
    output rcpwc_pkg::sts_t                            sts,
    input  wire logic                                  mode,
    input  wire logic [rcpwc_pkg::TICK_BITS-1:0]       capture_ticks,
    input  wire logic [rcpwc_pkg::CLK_BITS-1:0]        timer_clock_hz,
    input  wire logic [rcpwc_pkg::WIDTH_BITS-1:0]      min_width_us,
    input  wire logic [rcpwc_pkg::WIDTH_BITS-1:0]      max_width_us,
    input  wire logic                                  out_stall,
    output logic                                       out_valid,
    output logic [rcpwc_pkg::WIDTH_BITS-1:0]           held_width_us,
    output logic [1:0]                                 status
);
    import rcpwc_pkg::*;

    localparam int unsigned PROD_W = COUNTER_BITS + US_BITS;

    // Latched event
    logic                    mode_reg;
    logic [COUNTER_BITS-1:0] ticks_reg;

    // Measurement state
    logic [COUNTER_BITS-1:0] rise_tick_reg;
    logic                    armed_reg;
    logic [WIDTH_BITS-1:0]   accepted_reg;

    // Divider: quotient shifts in from the right as the dividend shifts out
    logic [PROD_W-1:0]   quot_reg;
    logic [CLK_BITS-1:0] rem_reg;
    logic [CLK_BITS:0]   rem_shift;
    logic                rem_ge;
    logic [CLK_BITS:0]   rem_diff;
    logic [COUNTER_BITS-1:0] tick_diff;
    logic [PROD_W-1:0]   product;

    // Output register
    logic                  out_valid_reg;
    logic [WIDTH_BITS-1:0] out_width_reg;
    status_t               out_status_reg;

    logic [TICK_BITS-1:0]  width_q;
    logic                  in_limits;
    status_t               status_next;
    logic                  out_free;
    logic                  take_width;
    logic [WIDTH_BITS-1:0] held_next;

    assign tick_diff = ticks_reg - rise_tick_reg;
    assign product   = PROD_W'(tick_diff) * PROD_W'(US_PER_SECOND);
    assign rem_shift = {rem_reg, quot_reg[PROD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, timer_clock_hz};
    assign rem_diff  = rem_shift - {1'b0, timer_clock_hz};

    // A zero divisor makes every step succeed, so the quotient is all ones
    assign width_q   = quot_reg[TICK_BITS-1:0];
    assign in_limits = (width_q >= TICK_BITS'(min_width_us))
                    && (width_q <= TICK_BITS'(max_width_us));

    // Held width after this event: the new width only on an armed fall in limits
    assign take_width = mode_reg && armed_reg && in_limits;
    assign held_next  = take_width ? width_q[WIDTH_BITS-1:0] : accepted_reg;

    assign out_free       = !out_valid_reg || !out_stall;
    assign sts.out_free   = out_free;
    assign sts.fall_armed = mode_reg && armed_reg;

    always_comb
    begin
        if (!mode_reg)
            status_next = STATUS_RISE;
        else if (!armed_reg)
            status_next = STATUS_NO_RISE;
        else if (in_limits)
            status_next = STATUS_ACCEPT;
        else
            status_next = STATUS_REJECT;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            ticks_reg <= capture_ticks[COUNTER_BITS-1:0];
        end
        if (cmd.mul)
        begin
            quot_reg <= product;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[PROD_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_diff[CLK_BITS-1:0] : rem_shift[CLK_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_tick_reg  <= '0;
            armed_reg      <= 1'b0;
            accepted_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_width_reg  <= '0;
            out_status_reg <= STATUS_RISE;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= status_next;
                out_width_reg  <= held_next;
                accepted_reg   <= held_next;
                if (!mode_reg)
                begin
                    rise_tick_reg <= ticks_reg;
                    armed_reg     <= 1'b1;
                end
                else if (armed_reg)
                begin
                    armed_reg <= 1'b0;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign held_width_us = out_width_reg;
    assign status        = out_status_reg;

endmodule

`default_nettype wire

### rtl/rc_pulse_width_capture_top.sv
// Top level of the RC pulse width capture block: configuration registers on
// an APB-style port, controller and datapath. Depends on rcpwc_pkg,
// rcpwc_ctrl and rcpwc_dp.
// A rise or an unarmed fall is committed to the output register from the decide
// state; an armed fall first passes the multiplier and the bit-serial divider.
// One event at a time: the next transfer waits until the last is committed, and
// waits while the output stalls.
// Reset (rst_n low, asynchronous) disarms the block, clears the held width and
// restores the default registers.
`default_nettype none

module rc_pulse_width_capture_top #(
    parameter int unsigned COUNTER_BITS = 32   // 16 .. 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Event input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [31:0] capture_ticks,

    // Result output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      held_width_us,
    output logic [1:0]       status,

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rcpwc_pkg::*;

    logic [CLK_BITS-1:0]   clock_hz_reg;
    logic [WIDTH_BITS-1:0] min_us_reg;
    logic [WIDTH_BITS-1:0] max_us_reg;
    logic                  cfg_write;
    logic [1:0]            cfg_index;

    cmd_t cmd;
    sts_t sts;

    // The port never waits; a write lands in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    // Registers are to change only while idle (the block does not enforce this), so the datapath reads them directly.
    // Drop bits above each register's width; ignore unknown addresses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= RESET_CLOCK_HZ;
            min_us_reg   <= RESET_MIN_US;
            max_us_reg   <= RESET_MAX_US;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CLOCK_HZ: clock_hz_reg <= pwdata[CLK_BITS-1:0];
                REG_MIN_US:   min_us_reg   <= pwdata[WIDTH_BITS-1:0];
                REG_MAX_US:   max_us_reg   <= pwdata[WIDTH_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Read back the register at the addressed slot, zero elsewhere
    always_comb
    begin
        case (cfg_index)
            REG_CLOCK_HZ: prdata = 32'(clock_hz_reg);
            REG_MIN_US:   prdata = 32'(min_us_reg);
            REG_MAX_US:   prdata = 32'(max_us_reg);
            default:      prdata = '0;
        endcase
    end

    // Sequence each transfer: latch, decide, multiply and divide on an armed fall, commit
    rcpwc_ctrl #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the edge state, scale the tick difference and check the limits
    rcpwc_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .mode           (mode),
        .capture_ticks  (capture_ticks),
        .timer_clock_hz (clock_hz_reg),
        .min_width_us   (min_us_reg),
        .max_width_us   (max_us_reg),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .held_width_us  (held_width_us),
        .status         (status)
    );

endmodule

`default_nettype wire

### sim/rc_pulse_width_capture_top_tb.sv
// Self-checking testbench for rc_pulse_width_capture_top: edge events in,
// width reports out, limits and timer clock programmed over the APB port.
// Depends on rcpwc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module rc_pulse_width_capture_top_tb;

    import rcpwc_pkg::*;

    localparam int unsigned COUNTER_BITS = 32;
    localparam logic [31:0] TICK_MASK =
        (COUNTER_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COUNTER_BITS) - 32'd1);

    // Edge polarity on the mode input
    localparam logic EDGE_RISE = 1'b0;
    localparam logic EDGE_FALL = 1'b1;

    // Register index with no register behind it; writes must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [15:0] report_us;
        status_t     code;
    } width_report_t;

    // Predicts the width report of every edge event and checks the block's
    // reports against the oldest pending prediction.
    class width_capture_predictor;
        logic [27:0]   clock_hz;
        logic [15:0]   min_us;
        logic [15:0]   max_us;
        logic [31:0]   rise_tick;
        logic          armed;
        logic [15:0]   held_us;
        width_report_t pending_reports[$];
        int            failures;

        function new();
            clock_hz  = RESET_CLOCK_HZ;
            min_us    = RESET_MIN_US;
            max_us    = RESET_MAX_US;
            rise_tick = '0;
            armed     = 1'b0;
            held_us   = '0;
            failures  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_CLOCK_HZ: clock_hz = value[27:0];
                REG_MIN_US:   min_us   = value[15:0];
                REG_MAX_US:   max_us   = value[15:0];
                default:      ;
            endcase
        endfunction

        // Ticks to microseconds with a 64-bit product; a zero clock saturates
        function logic [31:0] ticks_to_us(logic [31:0] span);
            logic [63:0] product;
            product = 64'(span) * 64'(US_PER_SECOND);
            if (clock_hz == '0)
                return 32'hFFFF_FFFF;
            return 32'(product / 64'(clock_hz));
        endfunction

        function void note_event(logic falling, logic [31:0] ticks_in);
            logic [31:0]   ticks;
            logic [31:0]   measured_us;
            width_report_t rep;
            ticks = ticks_in & TICK_MASK;
            if (falling == EDGE_RISE)
            begin
                rise_tick = ticks;
                armed     = 1'b1;
                rep.code  = STATUS_RISE;
            end
            else if (!armed)
            begin
                rep.code = STATUS_NO_RISE;
            end
            else
            begin
                measured_us = ticks_to_us((ticks - rise_tick) & TICK_MASK);
                armed       = 1'b0;
                if (measured_us >= 32'(min_us) && measured_us <= 32'(max_us))
                begin
                    held_us  = measured_us[15:0];
                    rep.code = STATUS_ACCEPT;
                end
                else
                begin
                    rep.code = STATUS_REJECT;
                end
            end
            rep.report_us = held_us;
            pending_reports.push_back(rep);
        endfunction

        function void complain(string what);
            failures++;
            if (failures <= 10)
                $display("%t: %s", $realtime, what);
        endfunction

        function void check_report(logic [15:0] got_us, logic [1:0] code);
            width_report_t want;
            if (pending_reports.size() == 0)
            begin
                complain($sformatf("unexpected report: width %0d status %0d",
                                   got_us, code));
                return;
            end
            want = pending_reports.pop_front();
            if (got_us !== want.report_us || code !== want.code)
                complain($sformatf({"report mismatch: expected width %0d status %s, ",
                                    "got width %0d status %0d"},
                                   want.report_us, want.code.name(), got_us, code));
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction
    endclass

    // Block inputs, all known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        mode = EDGE_RISE;
    logic [31:0] capture_ticks = '0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    // Block outputs
    logic        in_stall;
    logic        out_valid;
    logic [15:0] held_width_us;
    logic [1:0]  status;
    logic [31:0] prdata;
    logic        pready;

    width_capture_predictor capture_pred;

    int items_sent = 0;
    int idle_pct = 0;        // chance in percent that the sender skips a cycle
    int stall_pct = 0;       // chance in percent that the receiver stalls
    bit hold_request = 1'b0; // ask the receiver for one long hold-off
    int hold_left = 0;
    int stuck_cycles = 0;

    rc_pulse_width_capture_top #(
        .COUNTER_BITS(COUNTER_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .capture_ticks(capture_ticks),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .held_width_us(held_width_us),
        .status(status),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #1 clk = ~clk;

    // Receiver: random stalls, plus one long hold-off on request so the block
    // fills up and pushes back on the event input.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: check each report transfer, then predict from each event
    // transfer. A report is registered only after its event is latched and decided,
    // so the order here never pairs an event with its own report in the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                capture_pred.check_report(held_width_us, status);
            if (in_valid && !in_stall)
                capture_pred.note_event(mode, capture_ticks);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT)
                begin
                    $display("[rc_pulse_width_capture_top] ERROR");
                    $finish;
                end
            end
        end
    end

    // Offer one edge event and return at the edge where it transfers. Valid
    // stays high afterwards so a following event can go back to back.
    task automatic send_event(input logic falling, input logic [31:0] ticks);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= falling;
        capture_ticks <= ticks;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_pulse(input logic [31:0] rise_at, input logic [31:0] fall_at);
        send_event(EDGE_RISE, rise_at);
        send_event(EDGE_FALL, fall_at);
    endtask

    // Drop valid and wait until every predicted report has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (capture_pred.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB write: setup cycle, access cycle, then release the bus.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        capture_pred.write_reg(idx, value);
        @(posedge clk);
    endtask

    // Program all three registers; junk in the unused upper bits must be dropped.
    task automatic program_limits(input logic [27:0] clock_hz, input logic [15:0] min_us,
                                  input logic [15:0] max_us);
        write_register(REG_CLOCK_HZ, {4'($urandom), clock_hz});
        write_register(REG_MIN_US, {16'($urandom), min_us});
        write_register(REG_MAX_US, {16'($urandom), max_us});
    endtask

    // Pick a tick span that lands near the programmed window, sometimes
    // right on an edge of it, sometimes anywhere.
    function automatic logic [31:0] pick_span();
        int unsigned lo;
        int unsigned hi;
        int unsigned target;
        logic [63:0] scaled;
        lo = (capture_pred.min_us < capture_pred.max_us) ? capture_pred.min_us
                                                         : capture_pred.max_us;
        hi = (capture_pred.min_us < capture_pred.max_us) ? capture_pred.max_us
                                                         : capture_pred.min_us;
        if (capture_pred.clock_hz == '0 || $urandom_range(19) == 0)
            return $urandom;
        case ($urandom_range(7))
            0:       target = capture_pred.min_us;
            1:       target = capture_pred.max_us;
            default: target = $urandom_range(hi + 200, (lo > 200) ? lo - 200 : 0);
        endcase
        scaled = (64'(target) * 64'(capture_pred.clock_hz) + 64'd999999) / 64'd1000000;
        if ($urandom_range(1))
            return scaled[31:0];
        return scaled[31:0] + 32'($urandom_range(3)) - 32'($urandom_range(3));
    endfunction

    // Mostly complete rise/fall pairs with random content; the rest is
    // repeated rises, stray falls and plain noise.
    task automatic run_random(input int count);
        int          goal;
        int          pick;
        logic [31:0] start;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            pick  = $urandom_range(99);
            start = $urandom;
            if (pick < 65)
            begin
                send_pulse(start, start + pick_span());
            end
            else if (pick < 78)
            begin
                send_event(EDGE_RISE, $urandom);
                send_pulse(start, start + pick_span());
            end
            else if (pick < 88)
            begin
                send_event(EDGE_FALL, start);
            end
            else
            begin
                send_event(1'($urandom), start);
            end
        end
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        idle_pct  = sender_pct;
        stall_pct = receiver_pct;
    endtask

    initial
    begin
        capture_pred = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at the reset settings: 1 MHz timer, 800..2200 us window
        set_idling(0, 0);
        send_event(EDGE_FALL, 32'd0);                    // fall with nothing armed
        send_pulse(32'd0, 32'd1500);                     // plain accept
        send_event(EDGE_RISE, 32'd1000);                 // rise while disarmed
        send_pulse(32'd5000, 32'd5800);                  // window minimum, inclusive
        send_pulse(32'hFFFF_FC00, 32'h0000_0498);        // counter wrap, window maximum
        send_pulse(32'd10, 32'd2211);                    // one above maximum
        send_pulse(32'd10, 32'd809);                     // one below minimum
        send_event(EDGE_FALL, 32'hFFFF_FFFF);            // disarmed after the reject
        send_pulse(32'd0, 32'hFFFF_FFFF);                // largest span
        send_pulse(32'hFFFF_FFFF, 32'hFFFF_FFFF);        // zero span
        send_pulse(32'hFFFF_FFFF, 32'd0);                // span of one tick
        send_pulse(32'hAAAA_AAAA, 32'hAAAA_B0AA);
        run_random(100);

        // Fastest timer, widest window; sender idles
        wait_drained();
        program_limits(28'd160000000, 16'd0, 16'd65535);
        set_idling(45, 0);
        run_random(110);

        // Slowest timer, so each tick is a millisecond; receiver stalls
        wait_drained();
        program_limits(28'd1000, 16'd1000, 16'd3000);
        set_idling(0, 45);
        run_random(110);

        // Zero timer clock: every armed fall saturates and is rejected
        wait_drained();
        program_limits(28'd0, 16'd800, 16'd2200);
        set_idling(27, 27);
        run_random(100);

        // Minimum above maximum: nothing can be accepted
        wait_drained();
        program_limits(28'($urandom_range(160000000, 1000)), 16'd3000, 16'd1000);
        set_idling(0, 0);
        run_random(100);

        // Write to an index with no register, then random settings
        wait_drained();
        write_register(REG_UNUSED, $urandom);
        program_limits(28'($urandom_range(160000000, 1000)),
                       16'($urandom_range(1500)), 16'($urandom_range(3000, 1500)));
        set_idling(27, 27);
        run_random(110);

        // Back pressure: hold the receiver off while events keep coming, then
        // pause the sender until the pipeline is empty before going on.
        wait_drained();
        program_limits(28'($urandom_range(160000000, 1000)),
                       16'($urandom_range(2000)), 16'($urandom_range(65535, 2000)));
        set_idling(45, 0);
        hold_request = 1'b1;
        run_random(60);
        wait_drained();
        run_random(60);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (capture_pred.failures == 0 && capture_pred.pending() == 0)
            $display("[rc_pulse_width_capture_top] OK");
        else
            $display("[rc_pulse_width_capture_top] ERROR");
        $finish;
    end

endmodule
